### design/theng_pkg.sv
// Shared types and constants of the timeout heap engine.
// Holds the item structs, heap entry layout, codes and sequencer states.
// No dependencies.
package theng_pkg;

   // Field widths
   localparam int TIME_W     = 32;
   localparam int CONN_W     = 10;
   localparam int KIND_W     = 3;
   localparam int OP_W       = 2;
   localparam int CONN_EXT_W = 17;

   // Default sizes
   localparam int MAX_CONNECTIONS_DEF = 1024;
   localparam int HEAP_DEPTH_DEF      = 64;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NONE      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [CONN_W-1:0] conn_id;
      logic [TIME_W-1:0] expire_time;
      logic [TIME_W-1:0] current_time;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [CONN_W-1:0] expired_conn;
      logic              last_result;
   } rsp_type;

   // Heap entry: ordering the whole word unsigned orders by deadline, then id
   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [CONN_W-1:0] conn;
   } heap_entry_type;

   localparam int ENTRY_W = TIME_W + CONN_W;

   typedef enum logic [15:0] {
      S_CLEAR     = 16'h0001,
      S_IDLE      = 16'h0002,
      S_DECODE    = 16'h0004,
      S_PUSH_CMP  = 16'h0008,
      S_PUSH_FIN  = 16'h0010,
      S_TICK_TOP  = 16'h0020,
      S_TICK_RDT  = 16'h0040,
      S_TICK_CHK  = 16'h0080,
      S_POP_START = 16'h0100,
      S_POP_X     = 16'h0200,
      S_POP_CHILD = 16'h0400,
      S_POP_L     = 16'h0800,
      S_POP_R     = 16'h1000,
      S_POP_CMP   = 16'h2000,
      S_TICK_FIN  = 16'h4000,
      S_DONE      = 16'h8000
   } state_type;

endpackage

### design/theng_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module theng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/theng_cmp.sv
// Shared compare unit of the timeout heap engine sequencer.
// Unsigned less-than and equality on two words. No dependencies.
module theng_cmp #(
   parameter int W = 42
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         lt,
   output logic         eq
);

   // Compare whole words
   assign lt = (a < b);
   assign eq = (a == b);

endmodule

### design/timeout_heap_engine_unit.sv
// Timeout heap engine: top level with the heap sequencer.
// Uses theng_pkg, theng_ram (heap and connection table) and theng_cmp.
//
// The engine keeps each connection's deadline in a table and a min-heap of
// (deadline, connection) pairs, ordered by deadline and then by smaller id.
// After reset it sweeps the connection table to clear the valid bits and
// holds req_stall high meanwhile. It works on one item at a time: a cancel
// clears the table entry of an id in range at decode; an add into an empty
// heap writes the root at decode, and otherwise moves the new entry up one
// heap level per parent compare that it wins (up to log2(HEAP_DEPTH)); a
// tick reads the top, checks it against the current time and the table,
// and pops each top entry that is due or no longer valid, sifting down. A
// stalled result holds the tick until it is taken. Pace is set by the single
// read port of the heap RAM and the one shared comparator. Expired results of
// one tick are delivered in heap order, the last one flagged by last_result.
module timeout_heap_engine_unit #(
   parameter int MAX_CONNECTIONS = theng_pkg::MAX_CONNECTIONS_DEF,
   parameter int HEAP_DEPTH      = theng_pkg::HEAP_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  theng_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output theng_pkg::rsp_type rsp_data
);

   localparam int HW    = $clog2(HEAP_DEPTH);
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int IW    = HW + 2;
   localparam int CW    = $clog2(MAX_CONNECTIONS);
   localparam int TW    = theng_pkg::TIME_W;
   localparam int EW    = theng_pkg::ENTRY_W;

   theng_pkg::state_type      state_ff, state_in;
   logic [CW-1:0]             clr_ff, clr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   theng_pkg::req_type        req_ff, req_in;
   logic [HW-1:0]             i_ff, i_in;
   logic [HW-1:0]             m_ff, m_in;
   theng_pkg::heap_entry_type x_ff, x_in;
   theng_pkg::heap_entry_type md_ff, md_in;
   theng_pkg::heap_entry_type ld_ff, ld_in;
   theng_pkg::heap_entry_type top_ff, top_in;
   logic                      due_ff, due_in;
   logic                      hold_valid_ff, hold_valid_in;
   logic [theng_pkg::CONN_W-1:0] hold_conn_ff, hold_conn_in;
   logic [theng_pkg::KIND_W-1:0] res_kind_ff, res_kind_in;
   logic [theng_pkg::CONN_W-1:0] res_conn_ff, res_conn_in;
   logic                      rsp_valid_ff;
   theng_pkg::rsp_type        rsp_data_ff;

   // Memory ports
   logic                      heap_we;
   logic [HW-1:0]             heap_wa, heap_ra;
   theng_pkg::heap_entry_type heap_wd, heap_rd;
   logic                      tbl_we;
   logic [CW-1:0]             tbl_wa, tbl_ra;
   logic [TW:0]               tbl_wd, tbl_rd;

   // Compare unit
   logic [EW-1:0]             cmp_a, cmp_b;
   logic                      cmp_lt, cmp_eq;

   // Output side
   logic                      out_free;
   logic                      emit;
   theng_pkg::rsp_type        emit_data;

   // Index helpers
   logic [IW-1:0]             ch_l, ch_r, cnt_ext;
   logic [HW-1:0]             par_i, par_p, cnt_m1, cnt_par;
   logic [theng_pkg::CONN_EXT_W-1:0] id_ext, rd_conn_ext;
   logic [CW-1:0]             id_addr, rd_conn_addr;
   logic                      id_in_range;
   logic                      tbl_valid;
   logic [TW-1:0]             tbl_deadline;
   logic                      pop_it, fire;

   assign ch_l    = {1'b0, i_ff, 1'b1};
   assign ch_r    = ch_l + IW'(1);
   assign cnt_ext = IW'(count_ff);
   assign par_i   = HW'(i_ff - HW'(1)) >> 1;
   assign par_p   = HW'(par_i - HW'(1)) >> 1;
   assign cnt_m1  = HW'(count_ff - CNT_W'(1));
   assign cnt_par = cnt_m1 >> 1;

   assign id_ext       = theng_pkg::CONN_EXT_W'(req_ff.conn_id);
   assign id_addr      = id_ext[CW-1:0];
   assign rd_conn_ext  = theng_pkg::CONN_EXT_W'(heap_rd.conn);
   assign rd_conn_addr = rd_conn_ext[CW-1:0];
   assign id_in_range  = (32'(req_ff.conn_id) < 32'(MAX_CONNECTIONS));

   assign tbl_valid    = tbl_rd[TW];
   assign tbl_deadline = tbl_rd[TW-1:0];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != theng_pkg::S_IDLE);

   // Tick decisions on the top entry
   assign pop_it = !tbl_valid || due_ff;
   assign fire   = tbl_valid && due_ff && cmp_eq;

   theng_ram #(
      .WIDTH(EW),
      .DEPTH(HEAP_DEPTH)
   ) u_heap_ram (
      .clock  (clock),
      .wr_en  (heap_we),
      .wr_addr(heap_wa),
      .wr_data(heap_wd),
      .rd_addr(heap_ra),
      .rd_data(heap_rd)
   );

   theng_ram #(
      .WIDTH(TW + 1),
      .DEPTH(MAX_CONNECTIONS)
   ) u_tbl_ram (
      .clock  (clock),
      .wr_en  (tbl_we),
      .wr_addr(tbl_wa),
      .wr_data(tbl_wd),
      .rd_addr(tbl_ra),
      .rd_data(tbl_rd)
   );

   theng_cmp #(
      .W(EW)
   ) u_cmp (
      .a (cmp_a),
      .b (cmp_b),
      .lt(cmp_lt),
      .eq(cmp_eq)
   );

   // Steer the shared comparator
   always_comb begin
      cmp_a = '0;
      cmp_b = '0;
      case (state_ff)
         theng_pkg::S_PUSH_CMP: begin
            cmp_a = x_ff;
            cmp_b = heap_rd;
         end
         theng_pkg::S_TICK_RDT: begin
            cmp_a = {heap_rd.deadline, theng_pkg::CONN_W'(0)};
            cmp_b = {req_ff.current_time, theng_pkg::CONN_W'(0)};
         end
         theng_pkg::S_TICK_CHK: begin
            cmp_a = {tbl_deadline, theng_pkg::CONN_W'(0)};
            cmp_b = {top_ff.deadline, theng_pkg::CONN_W'(0)};
         end
         theng_pkg::S_POP_R: begin
            cmp_a = heap_rd;
            cmp_b = ld_ff;
         end
         theng_pkg::S_POP_CMP: begin
            cmp_a = md_ff;
            cmp_b = x_ff;
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      req_in        = req_ff;
      i_in          = i_ff;
      m_in          = m_ff;
      x_in          = x_ff;
      md_in         = md_ff;
      ld_in         = ld_ff;
      top_in        = top_ff;
      due_in        = due_ff;
      hold_valid_in = hold_valid_ff;
      hold_conn_in  = hold_conn_ff;
      res_kind_in   = res_kind_ff;
      res_conn_in   = res_conn_ff;
      heap_we       = 1'b0;
      heap_wa       = i_ff;
      heap_wd       = x_ff;
      heap_ra       = '0;
      tbl_we        = 1'b0;
      tbl_wa        = id_addr;
      tbl_wd        = '0;
      tbl_ra        = rd_conn_addr;
      emit          = 1'b0;
      emit_data     = '0;
      case (state_ff)
         theng_pkg::S_CLEAR: begin
            // Sweep the connection table, one entry a cycle
            tbl_we = 1'b1;
            tbl_wa = clr_ff;
            tbl_wd = '0;
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(MAX_CONNECTIONS - 1)) begin
               state_in = theng_pkg::S_IDLE;
            end
         end
         theng_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = theng_pkg::S_DECODE;
            end
         end
         theng_pkg::S_DECODE: begin
            res_conn_in = req_ff.conn_id;
            case (req_ff.opcode)
               theng_pkg::OP_ADD: begin
                  if (!id_in_range || (32'(count_ff) >= 32'(HEAP_DEPTH))) begin
                     res_kind_in = theng_pkg::KIND_REJECTED;
                     state_in    = theng_pkg::S_DONE;
                  end else begin
                     // Register the deadline and start the push
                     tbl_we      = 1'b1;
                     tbl_wd      = {1'b1, req_ff.expire_time};
                     res_kind_in = theng_pkg::KIND_ADDED;
                     x_in        = {req_ff.expire_time, req_ff.conn_id};
                     i_in        = HW'(count_ff);
                     count_in    = count_ff + CNT_W'(1);
                     if (count_ff == '0) begin
                        heap_we  = 1'b1;
                        heap_wa  = '0;
                        heap_wd  = {req_ff.expire_time, req_ff.conn_id};
                        state_in = theng_pkg::S_DONE;
                     end else begin
                        heap_ra  = cnt_par;
                        state_in = theng_pkg::S_PUSH_CMP;
                     end
                  end
               end
               theng_pkg::OP_CANCEL: begin
                  tbl_we      = id_in_range;
                  tbl_wd      = '0;
                  res_kind_in = theng_pkg::KIND_CANCELLED;
                  state_in    = theng_pkg::S_DONE;
               end
               theng_pkg::OP_TICK: begin
                  hold_valid_in = 1'b0;
                  state_in      = theng_pkg::S_TICK_TOP;
               end
               default: begin
                  state_in = theng_pkg::S_IDLE;
               end
            endcase
         end
         theng_pkg::S_PUSH_CMP: begin
            // Parent entry is on heap_rd; move it down while the new one wins
            heap_we = 1'b1;
            heap_wa = i_ff;
            if (cmp_lt) begin
               heap_wd = heap_rd;
               i_in    = par_i;
               if (par_i == '0) begin
                  state_in = theng_pkg::S_PUSH_FIN;
               end else begin
                  heap_ra = par_p;
               end
            end else begin
               heap_wd  = x_ff;
               state_in = theng_pkg::S_DONE;
            end
         end
         theng_pkg::S_PUSH_FIN: begin
            heap_we  = 1'b1;
            heap_wa  = i_ff;
            heap_wd  = x_ff;
            state_in = theng_pkg::S_DONE;
         end
         theng_pkg::S_TICK_TOP: begin
            heap_ra = '0;
            if (count_ff == '0) begin
               state_in = theng_pkg::S_TICK_FIN;
            end else begin
               state_in = theng_pkg::S_TICK_RDT;
            end
         end
         theng_pkg::S_TICK_RDT: begin
            // Latch the top, look up its connection, check if due
            top_in   = heap_rd;
            tbl_ra   = rd_conn_addr;
            due_in   = cmp_lt;
            state_in = theng_pkg::S_TICK_CHK;
         end
         theng_pkg::S_TICK_CHK: begin
            if (!pop_it) begin
               state_in = theng_pkg::S_TICK_FIN;
            end else if (!(fire && hold_valid_ff && !out_free)) begin
               // Release the held result and hold the new one
               if (fire) begin
                  emit          = hold_valid_ff;
                  emit_data     = {theng_pkg::KIND_EXPIRED, hold_conn_ff, 1'b0};
                  hold_valid_in = 1'b1;
                  hold_conn_in  = top_ff.conn;
               end
               count_in = count_ff - CNT_W'(1);
               state_in = theng_pkg::S_POP_START;
            end
         end
         theng_pkg::S_POP_START: begin
            heap_ra = HW'(count_ff);
            if (count_ff == '0) begin
               state_in = theng_pkg::S_TICK_TOP;
            end else begin
               state_in = theng_pkg::S_POP_X;
            end
         end
         theng_pkg::S_POP_X: begin
            x_in     = heap_rd;
            i_in     = '0;
            state_in = theng_pkg::S_POP_CHILD;
         end
         theng_pkg::S_POP_CHILD: begin
            if (ch_l >= cnt_ext) begin
               heap_we  = 1'b1;
               heap_wa  = i_ff;
               heap_wd  = x_ff;
               state_in = theng_pkg::S_TICK_TOP;
            end else begin
               heap_ra  = ch_l[HW-1:0];
               state_in = theng_pkg::S_POP_L;
            end
         end
         theng_pkg::S_POP_L: begin
            ld_in = heap_rd;
            if (ch_r < cnt_ext) begin
               heap_ra  = ch_r[HW-1:0];
               state_in = theng_pkg::S_POP_R;
            end else begin
               m_in     = ch_l[HW-1:0];
               md_in    = heap_rd;
               state_in = theng_pkg::S_POP_CMP;
            end
         end
         theng_pkg::S_POP_R: begin
            // Pick the smaller child
            if (cmp_lt) begin
               m_in  = ch_r[HW-1:0];
               md_in = heap_rd;
            end else begin
               m_in  = ch_l[HW-1:0];
               md_in = ld_ff;
            end
            state_in = theng_pkg::S_POP_CMP;
         end
         theng_pkg::S_POP_CMP: begin
            heap_we = 1'b1;
            heap_wa = i_ff;
            if (cmp_lt) begin
               heap_wd  = md_ff;
               i_in     = m_ff;
               state_in = theng_pkg::S_POP_CHILD;
            end else begin
               heap_wd  = x_ff;
               state_in = theng_pkg::S_TICK_TOP;
            end
         end
         theng_pkg::S_TICK_FIN: begin
            if (hold_valid_ff) begin
               res_kind_in = theng_pkg::KIND_EXPIRED;
               res_conn_in = hold_conn_ff;
            end else begin
               res_kind_in = theng_pkg::KIND_NONE;
               res_conn_in = '0;
            end
            hold_valid_in = 1'b0;
            state_in      = theng_pkg::S_DONE;
         end
         theng_pkg::S_DONE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = {res_kind_ff, res_conn_ff, 1'b1};
               state_in  = theng_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = theng_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= theng_pkg::S_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      i_ff         <= i_in;
      m_ff         <= m_in;
      x_ff         <= x_in;
      md_ff        <= md_in;
      ld_ff        <= ld_in;
      top_ff       <= top_in;
      due_ff       <= due_in;
      hold_conn_ff <= hold_conn_in;
      res_kind_ff  <= res_kind_in;
      res_conn_ff  <= res_conn_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(HEAP_DEPTH))
      else $error("heap count beyond depth");

   a_hold_in_tick : assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (state_ff != theng_pkg::S_IDLE))
      else $error("held result left over in idle");

   a_emit_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == theng_pkg::S_DONE ||
                               $past(state_ff) == theng_pkg::S_TICK_CHK))
      else $error("result from unexpected state");

   a_clear_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == theng_pkg::S_CLEAR) |-> (count_ff == '0))
      else $error("heap not empty during table sweep");
`endif

endmodule
